>>> hw/rtl/dsl_pkg.sv
// Shared types, codes and table-building functions for the dense sigmoid layer.
`timescale 1ns / 1ps

package dsl_pkg;

   // default sizes
   localparam int DEF_MAX_INPUTS   = 16;
   localparam int DEF_MAX_OUTPUTS  = 16;
   localparam int DEF_TABLE_ENTRIES = 512;

   // accumulator rows, fixed by the 4-bit row and column fields
   localparam int SUM_DEPTH = 16;
   // front-to-back queue depth
   localparam int Q_DEPTH   = 4;

   // Q4.12 one and exp(-1/4096) in Q0.32
   localparam logic [63:0] ONE_Q12  = 64'd4096;
   localparam logic [63:0] EXP_STEP = 64'hFFF00080;

   // request commands
   localparam logic [1:0] CMD_WGT  = 2'd0;
   localparam logic [1:0] CMD_BIAS = 2'd1;
   localparam logic [1:0] CMD_FWD  = 2'd2;
   localparam logic [1:0] CMD_BWD  = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_ACT   = 2'd0;
   localparam logic [1:0] KIND_DELTA = 2'd1;
   localparam logic [1:0] KIND_GAMMA = 2'd2;

   // csr indexes
   localparam logic CSR_IN_COUNT  = 1'b0;
   localparam logic CSR_OUT_COUNT = 1'b1;

   typedef enum logic [2:0] {
      OP_WGT,
      OP_BIAS,
      OP_DROP,
      OP_FWD,
      OP_BWD
   } dsl_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_BW_M1,
      ST_BW_M2,
      ST_BW_DELTA,
      ST_EMIT_RD,
      ST_EMIT_IDX,
      ST_EMIT_OUT,
      ST_GAMMA
   } dsl_state_type;

   // classified work item passed through the queue
   typedef struct packed {
      dsl_op_type         op;
      logic [3:0]         row;
      logic [3:0]         col;
      logic signed [15:0] value;
      logic signed [15:0] grad;
      logic               last;
      logic               active;
   } dsl_item_type;

   // effective row and column counts
   typedef struct packed {
      logic [4:0] rows;
      logic [4:0] cols;
   } dsl_cnt_type;

   // min(reg, maxv, 16)
   function automatic logic [4:0] clamp_cnt(input logic [4:0] cnt_reg, input int maxv);
      logic [4:0] lim;
      lim = (maxv > 16) ? 5'd16 : 5'(maxv);
      return (cnt_reg > lim) ? lim : cnt_reg;
   endfunction

   // saturate to signed 16 bits
   function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
      logic signed [15:0] r;
      if (v > 40'sd32767)
         r = 16'sh7FFF;
      else if (v < -40'sd32768)
         r = 16'sh8000;
      else
         r = v[15:0];
      return r;
   endfunction

   // restoring divider, elaboration use only
   function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int k = 63; k >= 0; k--) begin
         rem = {rem[62:0], num[k]};
         if (rem >= den) begin
            rem = rem - den;
            quo[k] = 1'b1;
         end
      end
      return quo;
   endfunction

   // exp(-m/4096) in Q0.32 by square-and-multiply
   function automatic logic [63:0] neg_exp_q32(input logic [15:0] m);
      logic [63:0] r;
      logic [63:0] p;
      r = 64'h1_0000_0000;
      p = EXP_STEP;
      for (int b = 0; b < 16; b++) begin
         if (m[b])
            r = (r * p + 64'h8000_0000) >> 32;
         p = (p * p + 64'h8000_0000) >> 32;
      end
      return r;
   endfunction

   // sigmoid table entry i of n, Q4.12
   function automatic logic [15:0] sig_entry(input int unsigned i, input int unsigned n);
      logic [63:0] xs;
      logic signed [63:0] x;
      logic [15:0] mag;
      logic [63:0] e;
      logic [63:0] den;
      logic [63:0] num;
      xs  = udiv(64'(2 * i + 1) * 64'd32768, 64'(n));
      x   = $signed(xs) - 64'sd32768;
      mag = (x < 0) ? 16'(-x) : 16'(x);
      e   = neg_exp_q32(mag);
      den = 64'h1_0000_0000 + e;
      num = (x >= 0) ? (ONE_Q12 << 32) : (e * ONE_Q12);
      return 16'(udiv(num + (den >> 1), den));
   endfunction

endpackage

>>> hw/rtl/dense_sigmoid_layer_unit.sv
// Top level of the dense sigmoid layer: front queue plus MAC back end.
`timescale 1ns / 1ps
//
// Usage: req_* beats carry commands (weight write, bias write, forward element,
// backward item); rsp_* beats carry activations, deltas and column gammas.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// csr_wr_en with csr_index/csr_wdata sets in_count and out_count; the user must
// write them only while idle; the block does not enforce it. A four-entry
// queue decouples the request side from the back end, so requests keep flowing
// while a result waits in the output register. Forward elements and backward
// items share the single multiply-accumulate pipeline, which walks the weight
// RAM one entry per cycle: the rows of an element's column, or the columns of
// an item's row. A last forward element then emits each row by a bias read, a
// table index and a sigmoid lookup; a last backward item emits one gamma per
// column. Reset clears counts to 16, the sums and the queue; weights and biases
// hold no defined value until written. When rsp_stall is high the pending
// result holds and the back end pauses; req_stall rises once the queue is full.
//
module dense_sigmoid_layer_unit #(
   parameter int MAX_INPUTS    = dsl_pkg::DEF_MAX_INPUTS,
   parameter int MAX_OUTPUTS   = dsl_pkg::DEF_MAX_OUTPUTS,
   parameter int TABLE_ENTRIES = dsl_pkg::DEF_TABLE_ENTRIES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [3:0]         req_row,
   input  logic [3:0]         req_col,
   input  logic signed [15:0] req_value,
   input  logic signed [15:0] req_grad,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic [3:0]         rsp_index,
   output logic signed [15:0] rsp_value_res,
   output logic               rsp_last_res,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [4:0]         csr_wdata
);
   import dsl_pkg::*;

   logic         q_valid, q_pop;
   dsl_item_type q_item;
   dsl_cnt_type  q_cnt;

   dsl_front #(.MAX_INPUTS(MAX_INPUTS), .MAX_OUTPUTS(MAX_OUTPUTS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .req_row   (req_row),
      .req_col   (req_col),
      .req_value (req_value),
      .req_grad  (req_grad),
      .req_last  (req_last),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .q_cnt     (q_cnt)
   );

   dsl_back #(
      .MAX_INPUTS    (MAX_INPUTS),
      .MAX_OUTPUTS   (MAX_OUTPUTS),
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop),
      .q_cnt         (q_cnt),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_index     (rsp_index),
      .rsp_value_res (rsp_value_res),
      .rsp_last_res  (rsp_last_res)
   );

endmodule

>>> hw/rtl/dsl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dsl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we)
         mem_ff[waddr] <= wdata;
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/dsl_front.sv
// Front end: csr registers, request classification and the work queue.
`timescale 1ns / 1ps

module dsl_front #(
   parameter int MAX_INPUTS  = dsl_pkg::DEF_MAX_INPUTS,
   parameter int MAX_OUTPUTS = dsl_pkg::DEF_MAX_OUTPUTS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_cmd,
   input  logic [3:0]           req_row,
   input  logic [3:0]           req_col,
   input  logic signed [15:0]   req_value,
   input  logic signed [15:0]   req_grad,
   input  logic                 req_last,
   input  logic                 csr_wr_en,
   input  logic                 csr_index,
   input  logic [4:0]           csr_wdata,
   output logic                 q_valid,
   output dsl_pkg::dsl_item_type q_item,
   input  logic                 q_pop,
   output dsl_pkg::dsl_cnt_type q_cnt
);
   import dsl_pkg::*;

   localparam int QW = $clog2(Q_DEPTH);

   logic [4:0]   in_count_ff, in_count_in;
   logic [4:0]   out_count_ff, out_count_in;
   dsl_item_type fifo_ff [Q_DEPTH];
   logic [QW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QW:0]  count_ff, count_in;
   logic         accept;
   dsl_item_type item;

   // csr writes
   always_comb begin
      in_count_in  = in_count_ff;
      out_count_in = out_count_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IN_COUNT:  in_count_in  = csr_wdata;
            CSR_OUT_COUNT: out_count_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign q_cnt.rows = clamp_cnt(out_count_ff, MAX_OUTPUTS);
   assign q_cnt.cols = clamp_cnt(in_count_ff, MAX_INPUTS);

   // classify the incoming beat
   always_comb begin
      item.row    = req_row;
      item.col    = req_col;
      item.value  = req_value;
      item.grad   = req_grad;
      item.last   = req_last;
      item.active = 1'b0;
      item.op     = OP_DROP;
      unique case (req_cmd)
         CMD_WGT:
            item.op = (32'(req_row) < 32'(MAX_OUTPUTS) && 32'(req_col) < 32'(MAX_INPUTS))
                      ? OP_WGT : OP_DROP;
         CMD_BIAS:
            item.op = (32'(req_row) < 32'(MAX_OUTPUTS)) ? OP_BIAS : OP_DROP;
         CMD_FWD: begin
            item.op     = OP_FWD;
            item.active = (5'(req_col) < q_cnt.cols) && (q_cnt.rows != 5'd0);
         end
         CMD_BWD: begin
            item.op     = OP_BWD;
            item.active = (5'(req_row) < q_cnt.rows) && (q_cnt.cols != 5'd0);
         end
         default: ;
      endcase
   end

   // queue control
   assign req_stall = (count_ff == (QW+1)'(Q_DEPTH));
   assign accept    = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QW+1)'(accept) - (QW+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_count_ff  <= 5'd16;
         out_count_ff <= 5'd16;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
      end else begin
         in_count_ff  <= in_count_in;
         out_count_ff <= out_count_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (accept)
         fifo_ff[wr_ptr_ff] <= item;
   end

`ifndef SYNTHESIS
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      accept && !q_pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a beat");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QW+1)'(Q_DEPTH)) else $error("queue overflow");
`endif

endmodule

>>> hw/rtl/dsl_back.sv
// Back end: weight and bias stores, shared MAC pipeline, sigmoid and gradient emit.
`timescale 1ns / 1ps

module dsl_back #(
   parameter int MAX_INPUTS    = dsl_pkg::DEF_MAX_INPUTS,
   parameter int MAX_OUTPUTS   = dsl_pkg::DEF_MAX_OUTPUTS,
   parameter int TABLE_ENTRIES = dsl_pkg::DEF_TABLE_ENTRIES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  dsl_pkg::dsl_item_type q_item,
   output logic                  q_pop,
   input  dsl_pkg::dsl_cnt_type  q_cnt,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_kind,
   output logic [3:0]            rsp_index,
   output logic signed [15:0]    rsp_value_res,
   output logic                  rsp_last_res
);
   import dsl_pkg::*;

   localparam int WDEPTH = MAX_INPUTS * MAX_OUTPUTS;
   localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
   localparam int BAW    = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
   localparam int TW     = $clog2(TABLE_ENTRIES);

   dsl_state_type state_ff, state_in;
   dsl_item_type  cur_ff, cur_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic [4:0]    limit;

   // MAC pipeline
   logic               s1_valid_ff, s2_valid_ff;
   logic [3:0]         s1_idx_ff, s2_idx_ff;
   logic signed [31:0] prod_ff;
   logic signed [15:0] mul_b;

   // backward delta path
   logic signed [31:0] prod1_ff;
   logic signed [37:0] prod2_ff;
   logic signed [19:0] gy;
   logic signed [17:0] omy;
   logic signed [15:0] delta;
   logic signed [15:0] delta_ff, delta_in;

   // accumulators
   logic signed [39:0] fsum_ff [SUM_DEPTH];
   logic signed [39:0] gsum_ff [SUM_DEPTH];

   // activation path
   logic signed [15:0] pre;
   logic [31:0]        tprod;
   logic [TW-1:0]      tab_idx_ff;
   logic [15:0]        sig_tab [TABLE_ENTRIES];

   // stores
   logic [WAW-1:0] w_raddr, w_waddr;
   logic [15:0]    w_rdata;
   logic [BAW-1:0] b_raddr;
   logic [15:0]    b_rdata;

   // control
   logic       out_free;
   logic       wgt_we, bias_we, issue, cnt_clr, cnt_inc;
   logic       out_load, fsum_clr, gsum_clr;
   logic [1:0] out_kind;
   logic [3:0] out_index;
   logic signed [15:0] out_value;
   logic       out_last;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_kind_ff;
   logic [3:0]         rsp_index_ff;
   logic signed [15:0] rsp_value_ff;
   logic               rsp_last_ff;

   // constant sigmoid table
   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_sig
      assign sig_tab[g] = sig_entry(g, TABLE_ENTRIES);
   end

   dsl_ram #(.WIDTH(16), .DEPTH(WDEPTH), .AW(WAW)) u_wgt (
      .clock (clock),
      .we    (wgt_we),
      .waddr (w_waddr),
      .wdata (q_item.value),
      .raddr (w_raddr),
      .rdata (w_rdata)
   );

   dsl_ram #(.WIDTH(16), .DEPTH(MAX_OUTPUTS), .AW(BAW)) u_bias (
      .clock (clock),
      .we    (bias_we),
      .waddr (BAW'(q_item.row)),
      .wdata (q_item.value),
      .raddr (b_raddr),
      .rdata (b_rdata)
   );

   assign w_waddr = WAW'(int'(q_item.row) * MAX_INPUTS + int'(q_item.col));
   assign w_raddr = (cur_ff.op == OP_FWD)
                    ? WAW'(int'(cnt_ff) * MAX_INPUTS + int'(cur_ff.col))
                    : WAW'(int'(cur_ff.row) * MAX_INPUTS + int'(cnt_ff));
   assign b_raddr = BAW'(cnt_ff);

   assign limit    = (cur_ff.op == OP_FWD) ? q_cnt.rows : q_cnt.cols;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // delta arithmetic
   assign gy    = 20'(prod1_ff >>> 12);
   assign omy   = 18'sd4096 - 18'(cur_ff.value);
   assign delta = sat16(40'(prod2_ff >>> 12));
   assign mul_b = (cur_ff.op == OP_FWD) ? cur_ff.value : delta_ff;

   // pre-activation and table index
   assign pre   = sat16(40'(fsum_ff[cnt_ff[3:0]] >>> 12) + 40'($signed(b_rdata)));
   assign tprod = 32'({~pre[15], pre[14:0]}) * 32'(TABLE_ENTRIES);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:
            if (q_valid) begin
               if (q_item.op == OP_FWD)
                  state_in = q_item.active ? ST_MAC : (q_item.last ? ST_EMIT_RD : ST_IDLE);
               else if (q_item.op == OP_BWD)
                  state_in = ST_BW_M1;
            end
         ST_MAC:
            if (cnt_ff + 5'd1 >= limit)
               state_in = ST_DRAIN;
         ST_DRAIN:
            if (!s1_valid_ff && !s2_valid_ff) begin
               if (!cur_ff.last)
                  state_in = ST_IDLE;
               else
                  state_in = (cur_ff.op == OP_FWD) ? ST_EMIT_RD : ST_GAMMA;
            end
         ST_BW_M1:    state_in = ST_BW_M2;
         ST_BW_M2:    state_in = ST_BW_DELTA;
         ST_BW_DELTA:
            if (out_free)
               state_in = cur_ff.active ? ST_MAC : (cur_ff.last ? ST_GAMMA : ST_IDLE);
         ST_EMIT_RD:
            state_in = (cnt_ff >= q_cnt.rows) ? ST_IDLE : ST_EMIT_IDX;
         ST_EMIT_IDX: state_in = ST_EMIT_OUT;
         ST_EMIT_OUT:
            if (out_free)
               state_in = ST_EMIT_RD;
         ST_GAMMA:
            if (cnt_ff >= q_cnt.cols)
               state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      q_pop     = 1'b0;
      issue     = 1'b0;
      out_load  = 1'b0;
      cnt_inc   = 1'b0;
      fsum_clr  = 1'b0;
      gsum_clr  = 1'b0;
      out_kind  = KIND_ACT;
      out_index = cnt_ff[3:0];
      out_value = $signed(sig_tab[tab_idx_ff]);
      out_last  = (cnt_ff + 5'd1 == q_cnt.rows);
      unique case (state_ff)
         ST_IDLE:  q_pop = q_valid;
         ST_MAC: begin
            issue   = 1'b1;
            cnt_inc = 1'b1;
         end
         ST_BW_DELTA: begin
            out_load  = out_free;
            out_kind  = KIND_DELTA;
            out_index = cur_ff.row;
            out_value = delta;
            out_last  = cur_ff.last && (q_cnt.cols == 5'd0);
         end
         ST_EMIT_RD: fsum_clr = (cnt_ff >= q_cnt.rows);
         ST_EMIT_OUT: begin
            out_load = out_free;
            cnt_inc  = out_free;
         end
         ST_GAMMA: begin
            gsum_clr  = (cnt_ff >= q_cnt.cols);
            out_load  = out_free && (cnt_ff < q_cnt.cols);
            cnt_inc   = out_load;
            out_kind  = KIND_GAMMA;
            out_value = sat16(40'(gsum_ff[cnt_ff[3:0]] >>> 12));
            out_last  = (cnt_ff + 5'd1 == q_cnt.cols);
         end
         default: ;
      endcase
      wgt_we  = q_pop && (q_item.op == OP_WGT);
      bias_we = q_pop && (q_item.op == OP_BIAS);
      cnt_clr = (state_in != state_ff) &&
                (state_in == ST_MAC || state_in == ST_GAMMA ||
                 (state_in == ST_EMIT_RD && state_ff != ST_EMIT_OUT));
   end

   // datapath next values
   always_comb begin
      cur_in   = q_pop ? q_item : cur_ff;
      cnt_in   = cnt_clr ? 5'd0 : (cnt_inc ? cnt_ff + 5'd1 : cnt_ff);
      delta_in = (state_ff == ST_BW_DELTA) ? delta : delta_ff;
      rsp_valid_in = out_load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         s1_valid_ff  <= issue;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      delta_ff   <= delta_in;
      s1_idx_ff  <= cnt_ff[3:0];
      s2_idx_ff  <= s1_idx_ff;
      prod_ff    <= $signed(w_rdata) * mul_b;
      prod1_ff   <= cur_ff.grad * cur_ff.value;
      prod2_ff   <= 38'(gy) * 38'(omy);
      tab_idx_ff <= tprod[16 +: TW];
      if (out_load) begin
         rsp_kind_ff  <= out_kind;
         rsp_index_ff <= out_index;
         rsp_value_ff <= out_value;
         rsp_last_ff  <= out_last;
      end
   end

   // accumulators
   always_ff @(posedge clock) begin
      if (reset || fsum_clr) begin
         for (int i = 0; i < SUM_DEPTH; i++)
            fsum_ff[i] <= '0;
      end else if (s2_valid_ff && cur_ff.op == OP_FWD) begin
         fsum_ff[s2_idx_ff] <= fsum_ff[s2_idx_ff] + 40'(prod_ff);
      end
      if (reset || gsum_clr) begin
         for (int i = 0; i < SUM_DEPTH; i++)
            gsum_ff[i] <= '0;
      end else if (s2_valid_ff && cur_ff.op == OP_BWD) begin
         gsum_ff[s2_idx_ff] <= gsum_ff[s2_idx_ff] + 40'(prod_ff);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_index     = rsp_index_ff;
   assign rsp_value_res = rsp_value_ff;
   assign rsp_last_res  = rsp_last_ff;

`ifndef SYNTHESIS
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free) else $error("result overwrote a pending beat");
   a_mac_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MAC |-> cnt_ff < limit) else $error("MAC index past limit");
   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN && state_in != ST_DRAIN |-> !s1_valid_ff && !s2_valid_ff)
      else $error("left drain with MAC in flight");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == ST_IDLE) else $error("pop while busy");
`endif

endmodule

>>> tb/tb.sv
// Self-checking testbench for the dense sigmoid layer unit.
`timescale 1ns / 1ps

module tb;
   import dsl_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 200;
   localparam int LUT_SIZE       = 512;

   typedef struct {
      logic [1:0]         cmd;
      logic [3:0]         row;
      logic [3:0]         col;
      logic signed [15:0] value;
      logic signed [15:0] grad;
      logic               last;
   } req_beat_type;

   typedef struct {
      logic [1:0]         kind;
      logic [3:0]         index;
      logic signed [15:0] value;
      logic               last;
   } rsp_beat_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_cmd = '0;
   logic [3:0]         req_row = '0;
   logic [3:0]         req_col = '0;
   logic signed [15:0] req_value = '0;
   logic signed [15:0] req_grad = '0;
   logic               req_last = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_kind;
   logic [3:0]         rsp_index;
   logic signed [15:0] rsp_value_res;
   logic               rsp_last_res;
   logic               csr_wr_en = 1'b0;
   logic               csr_index = 1'b0;
   logic [4:0]         csr_wdata = '0;

   // model state
   logic signed [15:0] wgt_mem [16][16];
   logic signed [15:0] bias_mem [16];
   logic signed [39:0] fwd_acc [16];
   logic signed [39:0] grad_acc [16];
   logic [15:0]        sig_lut [LUT_SIZE];
   int                 in_cnt_reg = 16;
   int                 out_cnt_reg = 16;

   req_beat_type pending_reqs[$];
   rsp_beat_type expected_rsps[$];
   int           errors = 0;
   bit           quiet = 1'b0;
   int           watchdog = 0;

   dense_sigmoid_layer_unit uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // exp(-m/4096) in Q0.32
   function automatic logic [63:0] exp_q32(input int unsigned m);
      logic [63:0] r;
      logic [63:0] p;
      r = 64'h1_0000_0000;
      p = 64'hFFF00080;
      while (m != 0) begin
         if (m & 1)
            r = (r * p + 64'h8000_0000) >> 32;
         p = (p * p + 64'h8000_0000) >> 32;
         m = m >> 1;
      end
      return r;
   endfunction

   function automatic void fill_sig_lut();
      longint             x;
      logic [63:0]        e;
      logic [63:0]        den;
      logic [63:0]        num;
      for (int i = 0; i < LUT_SIZE; i++) begin
         x   = ((2 * i + 1) * 32768) / LUT_SIZE - 32768;
         e   = exp_q32(x < 0 ? -x : x);
         den = 64'h1_0000_0000 + e;
         num = (x >= 0) ? (64'd4096 << 32) : e * 64'd4096;
         sig_lut[i] = 16'((num + den / 2) / den);
      end
   endfunction

   function automatic longint clip_q12(input longint v);
      return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
   endfunction

   function automatic int eff_cnt(input int r);
      return r > 16 ? 16 : r;
   endfunction

   function automatic void add_rsp(input logic [1:0] k, input int idx, input longint v,
                                   input bit lst);
      rsp_beat_type b;
      b.kind  = k;
      b.index = 4'(idx);
      b.value = 16'(v);
      b.last  = lst;
      expected_rsps.push_back(b);
   endfunction

   // update state and queue the results caused by one accepted request
   function automatic void layer_step(input req_beat_type q);
      int     rows;
      int     cols;
      longint pre;
      longint gy;
      longint delta;
      longint prod;
      rows = eff_cnt(out_cnt_reg);
      cols = eff_cnt(in_cnt_reg);
      case (q.cmd)
         CMD_WGT: wgt_mem[q.row][q.col] = q.value;
         CMD_BIAS: bias_mem[q.row] = q.value;
         CMD_FWD: begin
            if (q.col < cols)
               for (int i = 0; i < rows; i++) begin
                  prod = longint'(wgt_mem[i][q.col]) * longint'(q.value);
                  fwd_acc[i] = fwd_acc[i] + 40'(prod);
               end
            if (q.last) begin
               for (int i = 0; i < rows; i++) begin
                  pre = clip_q12(longint'(fwd_acc[i] >>> 12) + longint'(bias_mem[i]));
                  add_rsp(KIND_ACT, i, sig_lut[(pre + 32768) >> 7], i + 1 == rows);
               end
               for (int i = 0; i < 16; i++) fwd_acc[i] = '0;
            end
         end
         default: begin
            gy    = (longint'(q.grad) * longint'(q.value)) >>> 12;
            delta = clip_q12((gy * (4096 - longint'(q.value))) >>> 12);
            if (q.row < rows)
               for (int i = 0; i < cols; i++) begin
                  prod = delta * longint'(wgt_mem[q.row][i]);
                  grad_acc[i] = grad_acc[i] + 40'(prod);
               end
            add_rsp(KIND_DELTA, q.row, delta, q.last && cols == 0);
            if (q.last) begin
               for (int i = 0; i < cols; i++)
                  add_rsp(KIND_GAMMA, i, clip_q12(longint'(grad_acc[i] >>> 12)),
                          i + 1 == cols);
               for (int i = 0; i < 16; i++) grad_acc[i] = '0;
            end
         end
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin
      logic         nxt_valid;
      req_beat_type cur;
      int           gap_left;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         nxt_valid = req_valid;
         if (req_valid && !req_stall) begin
            layer_step(cur);
            nxt_valid = 1'b0;
            gap_left = quiet ? 0 : $urandom_range(0, 4);
         end
         if (!nxt_valid) begin
            if (gap_left > 0)
               gap_left--;
            else if (pending_reqs.size() > 0) begin
               cur = pending_reqs.pop_front();
               nxt_valid = 1'b1;
               req_cmd   <= cur.cmd;
               req_row   <= cur.row;
               req_col   <= cur.col;
               req_value <= cur.value;
               req_grad  <= cur.grad;
               req_last  <= cur.last;
            end
         end
         req_valid <= nxt_valid;
      end
   end

   // result monitor and stall generator
   always @(posedge clock) begin
      rsp_beat_type exp_b;
      int           stall_left;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected result kind %0d index %0d value %0d",
                      rsp_kind, rsp_index, rsp_value_res);
               errors++;
            end else begin
               exp_b = expected_rsps.pop_front();
               if (rsp_kind !== exp_b.kind) begin
                  $error("kind: expected %0d, got %0d", exp_b.kind, rsp_kind);
                  errors++;
               end
               if (rsp_index !== exp_b.index) begin
                  $error("index: expected %0d, got %0d", exp_b.index, rsp_index);
                  errors++;
               end
               if (rsp_value_res !== exp_b.value) begin
                  $error("value_res: expected %0d, got %0d", exp_b.value, rsp_value_res);
                  errors++;
               end
               if (rsp_last_res !== exp_b.last) begin
                  $error("last_res: expected %0d, got %0d", exp_b.last, rsp_last_res);
                  errors++;
               end
            end
            stall_left = quiet ? 0 : $urandom_range(0, 4);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else
            rsp_stall <= 1'b0;
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
         watchdog <= 0;
      else
         watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic push_req(input logic [1:0] c, input int r, input int cl,
                           input int v, input int g, input bit lst);
      req_beat_type b;
      b.cmd   = c;
      b.row   = 4'(r);
      b.col   = 4'(cl);
      b.value = 16'(v);
      b.grad  = 16'(g);
      b.last  = lst;
      pending_reqs.push_back(b);
   endtask

   function automatic int rand_q12();
      case ($urandom_range(0, 5))
         0: return 32767;
         1: return -32768;
         2: return $urandom_range(0, 8192) - 4096;
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   task automatic wait_idle();
      @(negedge clock);
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_counts(input int ic, input int oc);
      wait_idle();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_IN_COUNT;
      csr_wdata <= 5'(ic);
      @(posedge clock);
      csr_index <= CSR_OUT_COUNT;
      csr_wdata <= 5'(oc);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      in_cnt_reg = ic;
      out_cnt_reg = oc;
      @(negedge clock);
   endtask

   // well-formed vectors with random content plus some noise
   task automatic random_phase(input int n_items);
      int cols;
      int rows;
      int n;
      int len;
      int kind_sel;
      cols = eff_cnt(in_cnt_reg);
      rows = eff_cnt(out_cnt_reg);
      n = 0;
      while (n < n_items) begin
         kind_sel = $urandom_range(0, 9);
         if (kind_sel <= 3) begin
            len = $urandom_range(1, cols > 0 ? cols + 1 : 2);
            for (int k = 0; k < len; k++)
               push_req(CMD_FWD, $urandom_range(0, 15),
                        ($urandom_range(0, 7) == 0 || cols == 0) ?
                           $urandom_range(0, 15) : $urandom_range(0, cols - 1),
                        rand_q12(), rand_q12(), k == len - 1);
            n += len;
         end else if (kind_sel <= 6) begin
            len = $urandom_range(1, 4);
            for (int k = 0; k < len; k++)
               push_req(CMD_BWD,
                        ($urandom_range(0, 5) == 0 || rows == 0) ?
                           $urandom_range(0, 15) : $urandom_range(0, rows - 1),
                        $urandom_range(0, 15),
                        $urandom_range(0, 1) ? $urandom_range(0, 4096) : rand_q12(),
                        rand_q12(), k == len - 1);
            n += len;
         end else if (kind_sel == 7) begin
            push_req($urandom_range(0, 1) ? CMD_WGT : CMD_BIAS, $urandom_range(0, 15),
                     $urandom_range(0, 15), rand_q12(), rand_q12(), $urandom_range(0, 1));
         end else begin
            push_req(2'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom_range(0, 15),
                     rand_q12(), rand_q12(), $urandom_range(0, 1));
            n++;
         end
      end
   endtask

   // stimulus
   initial begin
      for (int i = 0; i < 16; i++) begin
         fwd_acc[i] = '0;
         grad_acc[i] = '0;
      end
      fill_sig_lut();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // weights cover the 4 x 4 corner in use, every bias is defined;
      // rows 0 and 1 hold the extremes
      set_counts(4, 4);
      for (int r = 0; r < 16; r++) begin
         if (r < 4)
            for (int c = 0; c < 4; c++)
               push_req(CMD_WGT, r, c, r == 0 ? 32767 : (r == 1 ? -32768 : rand_q12()),
                        0, (r + c) % 2);
         push_req(CMD_BIAS, r, 0, r == 2 ? 32767 : (r == 3 ? -32768 : rand_q12()), 0, r % 2);
      end

      // directed: full forward vector with extreme elements
      for (int c = 0; c < 4; c++)
         push_req(CMD_FWD, 0, c, c % 3 == 0 ? 32767 : (c % 3 == 1 ? -32768 : 0),
                  0, c == 3);
      push_req(CMD_FWD, 15, 3, -32768, 32767, 1'b1);
      // directed: backward items at the y and g extremes
      push_req(CMD_BWD, 0, 0, 4096, 32767, 1'b0);
      push_req(CMD_BWD, 1, 15, -32768, -32768, 1'b0);
      push_req(CMD_BWD, 15, 0, 32767, 32767, 1'b0);
      push_req(CMD_BWD, 2, 0, 0, -1, 1'b1);

      // one row, one column: unused column forward, unused row backward
      set_counts(1, 1);
      push_req(CMD_FWD, 0, 5, 1234, 0, 1'b1);
      push_req(CMD_BWD, 3, 0, 2048, -32768, 1'b1);

      // no columns: forward adds nothing, last delta ends the run
      set_counts(0, 31);
      push_req(CMD_FWD, 0, 0, 32767, 0, 1'b1);
      push_req(CMD_BWD, 4, 0, 1000, 20000, 1'b1);

      // no rows: last forward emits nothing; every backward row unused
      set_counts(31, 0);
      push_req(CMD_FWD, 0, 2, 32767, 0, 1'b0);
      push_req(CMD_FWD, 0, 3, -5, 0, 1'b1);
      push_req(CMD_BWD, 7, 0, -32768, 32767, 1'b1);
      set_counts(4, 4);
      push_req(CMD_FWD, 0, 0, 4096, 0, 1'b1);

      // random phases over assorted counts within the defined corner
      random_phase(15);
      for (int p = 0; p < 3; p++) begin
         set_counts($urandom_range(0, 4), $urandom_range(0, 4));
         quiet = (p == 2);
         random_phase(15);
      end
      quiet = 1'b0;

      wait_idle();
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/dsl_pkg.sv
hw/rtl/dsl_ram.sv
hw/rtl/dsl_front.sv
hw/rtl/dsl_back.sv
hw/rtl/dense_sigmoid_layer_unit.sv
tb/tb.sv
